// ----- hw/rtl/tme_pkg.sv -----
// ============================================================================
// Tier migration evaluator package
// Shared widths, register codes, direction codes and arithmetic constants.
// ============================================================================
package tme_pkg;

    // Tier table
    localparam int TME_NUM_TIERS = 4;
    localparam int TIER_IDX_W    = 2;
    localparam int TIER_WORD_W   = 63;
    localparam int LAT_W         = 16;
    localparam int EN_W          = 16;
    localparam int BW_W          = 31;
    localparam int BW_LSB        = 32;

    // Configuration
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WEIGHT_W   = 16;
    localparam int THR_W      = 32;
    localparam int HOR_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIER0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIER1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIER2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIER3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EN_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_WEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON   = 3'd7;

    localparam logic [WEIGHT_W-1:0] EN_WEIGHT_RST  = 16'd19661;
    localparam logic [WEIGHT_W-1:0] LAT_WEIGHT_RST = 16'd45875;
    localparam logic [THR_W-1:0]    THRESHOLD_RST  = 32'd66;
    localparam logic [HOR_W-1:0]    HORIZON_RST    = 16'd1;

    // Item fields
    localparam int CNT_W   = 32;
    localparam int VEL_W   = 16;
    localparam int SIZE_W  = 32;
    localparam int DIR_W   = 2;
    localparam int VALUE_W = 64;
    localparam int COST_W  = 63;
    localparam int FRAC_W  = 16;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // Square root unit: one result bit per stage
    localparam int SQ_IN_W   = 32;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_STAGES = SQ_OUT_W;
    localparam int SQ_REM_W  = SQ_OUT_W + 3;

    // Divider: one quotient bit per stage
    localparam int DIV_NUM_W  = SIZE_W + FRAC_W;
    localparam int DIV_DEN_W  = BW_W;
    localparam int DIV_STAGES = DIV_NUM_W;

    // floor(x/10) = (x * RECIP10) >> RECIP10_SH for any 32-bit x
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int          RECIP10_SH = 35;

    function automatic logic [VEL_W-1:0] vel_mag(input logic [VEL_W-1:0] v);
        return v[VEL_W-1] ? VEL_W'(~v + 1'b1) : v;
    endfunction

endpackage

// ----- hw/rtl/tme_sqrt_pipe.sv -----
// ============================================================================
// Pipelined integer square root
// floor(sqrt(rad)), one root bit resolved per register stage.
// ============================================================================
module tme_sqrt_pipe
    import tme_pkg::*;
(
    input  logic                clk,
    input  logic [SQ_IN_W-1:0]  rad,
    output logic [SQ_OUT_W-1:0] root
);

    logic [SQ_REM_W-1:0] rem_reg  [SQ_STAGES];
    logic [SQ_OUT_W-1:0] root_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_STAGES];

    logic [SQ_REM_W-1:0] rem_next  [SQ_STAGES];
    logic [SQ_OUT_W-1:0] root_next [SQ_STAGES];
    logic [SQ_IN_W-1:0]  rad_next  [SQ_STAGES];

    always_comb
    begin
        logic [SQ_REM_W-1:0] p_rem;
        logic [SQ_OUT_W-1:0] p_root;
        logic [SQ_IN_W-1:0]  p_rad;
        logic [SQ_REM_W-1:0] cat;
        logic [SQ_REM_W-1:0] trial;
        for (int i = 0; i < SQ_STAGES; i++)
        begin
            if (i == 0)
            begin
                p_rem  = '0;
                p_root = '0;
                p_rad  = rad;
            end
            else
            begin
                p_rem  = rem_reg[i-1];
                p_root = root_reg[i-1];
                p_rad  = rad_reg[i-1];
            end
            cat   = {p_rem[SQ_REM_W-3:0], p_rad[SQ_IN_W-1 -: 2]};
            trial = {1'b0, p_root, 2'b01};
            if (cat >= trial)
            begin
                rem_next[i]  = cat - trial;
                root_next[i] = {p_root[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = cat;
                root_next[i] = {p_root[SQ_OUT_W-2:0], 1'b0};
            end
            rad_next[i] = {p_rad[SQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SQ_STAGES; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
            rad_reg[i]  <= rad_next[i];
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

// ----- hw/rtl/tme_div_pipe.sv -----
// ============================================================================
// Pipelined restoring divider
// floor(numer / den), one quotient bit resolved per register stage.
// ============================================================================
module tme_div_pipe
    import tme_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_NUM_W-1:0] numer,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quot
);

    logic [DIV_DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_NUM_W-1:0] quo_reg [DIV_STAGES];
    logic [DIV_NUM_W-1:0] num_reg [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_reg [DIV_STAGES];

    logic [DIV_DEN_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_NUM_W-1:0] quo_next [DIV_STAGES];
    logic [DIV_NUM_W-1:0] num_next [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_next [DIV_STAGES];

    always_comb
    begin
        logic [DIV_DEN_W-1:0] p_rem;
        logic [DIV_NUM_W-1:0] p_quo;
        logic [DIV_NUM_W-1:0] p_num;
        logic [DIV_DEN_W-1:0] p_den;
        logic [DIV_DEN_W:0]   cat;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                p_rem = '0;
                p_quo = '0;
                p_num = numer;
                p_den = den;
            end
            else
            begin
                p_rem = rem_reg[i-1];
                p_quo = quo_reg[i-1];
                p_num = num_reg[i-1];
                p_den = den_reg[i-1];
            end
            cat = {p_rem, p_num[DIV_NUM_W-1]};
            if (cat >= {1'b0, p_den})
            begin
                rem_next[i] = DIV_DEN_W'(cat - {1'b0, p_den});
                quo_next[i] = {p_quo[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = DIV_DEN_W'(cat);
                quo_next[i] = {p_quo[DIV_NUM_W-2:0], 1'b0};
            end
            num_next[i] = {p_num[DIV_NUM_W-2:0], 1'b0};
            den_next[i] = p_den;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
            num_reg[i] <= num_next[i];
            den_reg[i] <= den_next[i];
        end
    end

    assign quot = quo_reg[DIV_STAGES-1];

endmodule

// ----- hw/rtl/tier_migration_evaluator.sv -----
// ============================================================================
// Tier migration evaluator
// Scores one page move between memory tiers per transfer: gain, move cost,
// net benefit, direction and approval, in signed Q47.16 with saturation.
// ============================================================================
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  item in   start / busy         pinned hit_count vel_x vel_y vel_z
//                                 page_size src_tier to_tier
//  result    done (strobe)        direction approved gain move_cost net_gain
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
//  An item enters every cycle; busy is always low and cfg_ready always high.
//  Each result is shown for one cycle; its latency is set by the 48-stage
//  move-cost divider (one quotient bit per stage), with the 16-stage square
//  root and the gain multipliers alongside.
//  The receiver cannot stall, so nothing in the pipeline ever holds.
//  Reset clears the valid bits and tier words and loads the weight, threshold and horizon reset values only.
//
module tier_migration_evaluator
    import tme_pkg::*;
#(
    parameter int NUM_TIERS = TME_NUM_TIERS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // item transfer
    input  logic                      start,
    output logic                      busy,
    input  logic                      pinned,
    input  logic [CNT_W-1:0]          hit_count,
    input  logic signed [VEL_W-1:0]   vel_x,
    input  logic signed [VEL_W-1:0]   vel_y,
    input  logic signed [VEL_W-1:0]   vel_z,
    input  logic [SIZE_W-1:0]         page_size,
    input  logic [TIER_IDX_W-1:0]     src_tier,
    input  logic [TIER_IDX_W-1:0]     to_tier,
    // result strobe
    output logic                      done,
    output logic [DIR_W-1:0]          direction,
    output logic                      approved,
    output logic signed [VALUE_W-1:0] gain,
    output logic [COST_W-1:0]         move_cost,
    output logic signed [VALUE_W-1:0] net_gain,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;

    // Arithmetic widths
    localparam int COSTT_W = 2 * WEIGHT_W + 1;          // weighted tier cost
    localparam int PRED_W  = CNT_W + HOR_W;             // predicted accesses
    localparam int LSUM_W  = LAT_W + 2;                 // four 16-bit terms
    localparam int X10_W   = SQ_OUT_W + 8;              // norm * 256
    localparam int P10_W   = X10_W + 32;
    localparam int F_W     = P10_W - RECIP10_SH + 1;    // motion factor
    localparam int M_W     = COSTT_W + F_W;             // |D| * F
    localparam int ML_W    = M_W / 2;
    localparam int MH_W    = M_W - ML_W;
    localparam int PL_W    = PRED_W / 2;
    localparam int PH_W    = PRED_W - PL_W;
    localparam int PROD_W  = M_W + PRED_W;
    localparam int MAG_LSB = FRAC_W;
    localparam int MAG_TOP = FRAC_W + VALUE_W;          // first bit that saturates

    // Pipeline alignment, counted from the stage that feeds both units
    localparam int ALIGN_ROOT = SQ_STAGES;
    localparam int ALIGN_F    = ALIGN_ROOT + 1;
    localparam int ALIGN_M    = ALIGN_ROOT + 2;
    localparam int ALIGN_PP   = ALIGN_ROOT + 3;
    localparam int ALIGN_PROD = ALIGN_ROOT + 4;
    localparam int ALIGN_GAIN = ALIGN_ROOT + 5;
    localparam int ALIGN_QUOT = DIV_STAGES;
    localparam int GAIN_DLY   = ALIGN_QUOT - ALIGN_GAIN;
    localparam int PRE_STAGES = 3;
    localparam int PIPE_DEPTH = PRE_STAGES + ALIGN_QUOT + 3;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic                  pinned;
        logic [DIR_W-1:0]      dir;
        logic [COSTT_W-1:0]    ud;
        logic                  neg;
        logic [PRED_W-1:0]     pred;
        logic [LSUM_W-1:0]     lsum;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TIER_WORD_W-1:0] tier_reg [NUM_TIERS];
    logic [WEIGHT_W-1:0]    en_weight_reg;
    logic [WEIGHT_W-1:0]    lat_weight_reg;
    logic [THR_W-1:0]       threshold_reg;
    logic [HOR_W-1:0]       horizon_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIERS; i++)
                tier_reg[i] <= '0;
            en_weight_reg  <= EN_WEIGHT_RST;
            lat_weight_reg <= LAT_WEIGHT_RST;
            threshold_reg  <= THRESHOLD_RST;
            horizon_reg    <= HORIZON_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index) inside
                REG_TIER0, REG_TIER1, REG_TIER2, REG_TIER3:
                begin
                    // drop writes to tiers this build does not have
                    if (int'(cfg_index[TIER_IDX_W-1:0]) < NUM_TIERS)
                        tier_reg[cfg_index[IDX_W-1:0]] <= cfg_data[TIER_WORD_W-1:0];
                end
                REG_EN_WEIGHT:  en_weight_reg  <= cfg_data[WEIGHT_W-1:0];
                REG_LAT_WEIGHT: lat_weight_reg <= cfg_data[WEIGHT_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                REG_HORIZON:    horizon_reg    <= cfg_data[HOR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel alongside the data
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start && !busy};
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp tier indices, fetch tier words, velocity magnitudes
    // ------------------------------------------------------------------
    logic [TIER_IDX_W-1:0] ft_c;
    logic [TIER_IDX_W-1:0] tt_c;

    logic                   s1_pinned_reg;
    logic [VEL_W-1:0]       s1_mx_reg;
    logic [VEL_W-1:0]       s1_my_reg;
    logic [VEL_W-1:0]       s1_mz_reg;
    logic [CNT_W-1:0]       s1_base_reg;
    logic [SIZE_W-1:0]      s1_size_reg;
    logic [DIR_W-1:0]       s1_dir_reg;
    logic [TIER_WORD_W-1:0] s1_wf_reg;
    logic [TIER_WORD_W-1:0] s1_wt_reg;
    logic [DIR_W-1:0]       dir_c;

    always_comb
    begin
        // an index past the last tier means the last tier
        ft_c = (int'(src_tier) >= NUM_TIERS) ? TIER_IDX_W'(NUM_TIERS - 1) : src_tier;
        tt_c = (int'(to_tier) >= NUM_TIERS) ? TIER_IDX_W'(NUM_TIERS - 1) : to_tier;
        if (tt_c < ft_c)
            dir_c = DIR_UP;
        else if (tt_c > ft_c)
            dir_c = DIR_DOWN;
        else
            dir_c = DIR_NONE;
    end

    always_ff @(posedge clk)
    begin
        s1_pinned_reg <= pinned;
        s1_mx_reg     <= vel_mag(vel_x);
        s1_my_reg     <= vel_mag(vel_y);
        s1_mz_reg     <= vel_mag(vel_z);
        s1_base_reg   <= (hit_count == '0) ? CNT_W'(1) : hit_count;
        s1_size_reg   <= page_size;
        s1_dir_reg    <= dir_c;
        s1_wf_reg     <= tier_reg[ft_c[IDX_W-1:0]];
        s1_wt_reg     <= tier_reg[tt_c[IDX_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Stage 2: products (squares, weighted costs, prediction), min bandwidth
    // ------------------------------------------------------------------
    logic [LAT_W-1:0] lat_f, lat_t;
    logic [EN_W-1:0]  en_f, en_t;
    logic [BW_W-1:0]  bw_f, bw_t, bw_min;

    assign lat_f  = s1_wf_reg[LAT_W-1:0];
    assign lat_t  = s1_wt_reg[LAT_W-1:0];
    assign en_f   = s1_wf_reg[LAT_W +: EN_W];
    assign en_t   = s1_wt_reg[LAT_W +: EN_W];
    assign bw_f   = s1_wf_reg[BW_LSB +: BW_W];
    assign bw_t   = s1_wt_reg[BW_LSB +: BW_W];
    assign bw_min = (bw_f < bw_t) ? bw_f : bw_t;

    logic                   s2_pinned_reg;
    logic [DIR_W-1:0]       s2_dir_reg;
    logic [SQ_IN_W-1:0]     s2_sx_reg, s2_sy_reg, s2_sz_reg;
    logic [2*WEIGHT_W-1:0]  s2_lf_reg, s2_ef_reg, s2_lt_reg, s2_et_reg;
    logic [PRED_W-1:0]      s2_pred_reg;
    logic [LSUM_W-1:0]      s2_lsum_reg;
    logic [DIV_NUM_W-1:0]   s2_numer_reg;
    logic [DIV_DEN_W-1:0]   s2_bw_reg;

    always_ff @(posedge clk)
    begin
        s2_pinned_reg <= s1_pinned_reg;
        s2_dir_reg    <= s1_dir_reg;
        s2_sx_reg     <= SQ_IN_W'(s1_mx_reg) * SQ_IN_W'(s1_mx_reg);
        s2_sy_reg     <= SQ_IN_W'(s1_my_reg) * SQ_IN_W'(s1_my_reg);
        s2_sz_reg     <= SQ_IN_W'(s1_mz_reg) * SQ_IN_W'(s1_mz_reg);
        s2_lf_reg     <= (2*WEIGHT_W)'(lat_weight_reg) * (2*WEIGHT_W)'(lat_f);
        s2_ef_reg     <= (2*WEIGHT_W)'(en_weight_reg) * (2*WEIGHT_W)'(en_f);
        s2_lt_reg     <= (2*WEIGHT_W)'(lat_weight_reg) * (2*WEIGHT_W)'(lat_t);
        s2_et_reg     <= (2*WEIGHT_W)'(en_weight_reg) * (2*WEIGHT_W)'(en_t);
        s2_pred_reg   <= PRED_W'(s1_base_reg) * PRED_W'(horizon_reg);
        s2_lsum_reg   <= LSUM_W'(lat_f) + LSUM_W'(lat_t) + LSUM_W'(en_f) + LSUM_W'(en_t);
        s2_numer_reg  <= {s1_size_reg, {FRAC_W{1'b0}}};
        s2_bw_reg     <= (bw_min == '0) ? DIV_DEN_W'(1) : bw_min;
    end

    // ------------------------------------------------------------------
    // Stage 3: cost difference and sum of squares; feeds both units
    // ------------------------------------------------------------------
    logic [COSTT_W-1:0] cost_f, cost_t;
    side_t              side_next;

    always_comb
    begin
        cost_f = COSTT_W'(s2_lf_reg) + COSTT_W'(s2_ef_reg);
        cost_t = COSTT_W'(s2_lt_reg) + COSTT_W'(s2_et_reg);
        side_next.pinned = s2_pinned_reg;
        side_next.dir    = s2_dir_reg;
        side_next.neg    = cost_t > cost_f;
        side_next.ud     = (cost_t > cost_f) ? cost_t - cost_f : cost_f - cost_t;
        side_next.pred   = s2_pred_reg;
        side_next.lsum   = s2_lsum_reg;
    end

    logic [SQ_IN_W-1:0]   sqsum_reg;
    logic [DIV_NUM_W-1:0] s3_numer_reg;
    logic [DIV_DEN_W-1:0] s3_bw_reg;
    side_t                side_reg [ALIGN_QUOT+1];

    always_ff @(posedge clk)
    begin
        sqsum_reg    <= s2_sx_reg + s2_sy_reg + s2_sz_reg;
        s3_numer_reg <= s2_numer_reg;
        s3_bw_reg    <= s2_bw_reg;
        side_reg[0]  <= side_next;
        // advance the side band in step with the units
        for (int k = 1; k <= ALIGN_QUOT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Velocity norm and move-cost quotient
    // ------------------------------------------------------------------
    logic [SQ_OUT_W-1:0]  sq_root;
    logic [DIV_NUM_W-1:0] quot;

    tme_sqrt_pipe u_sqrt
    (
        .clk  (clk),
        .rad  (sqsum_reg),
        .root (sq_root)
    );

    tme_div_pipe u_div
    (
        .clk   (clk),
        .numer (s3_numer_reg),
        .den   (s3_bw_reg),
        .quot  (quot)
    );

    // ------------------------------------------------------------------
    // Gain chain: motion factor, |D|*F, partial products, sum, saturate
    // ------------------------------------------------------------------
    logic [P10_W-1:0]  p10;
    logic [F_W-1:0]    f_reg;
    logic [M_W-1:0]    m_reg;
    logic [PROD_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VALUE_W-1:0] mag;
    logic signed [VALUE_W-1:0] gain_next;
    logic signed [VALUE_W-1:0] gain_dly_reg [GAIN_DLY+1];

    // floor(norm*256/10) through the reciprocal of ten
    assign p10 = P10_W'({sq_root, 8'd0}) * P10_W'(RECIP10);

    always_comb
    begin
        mag = (prod_reg[PROD_W-1:MAG_TOP] != '0) ? '1 : prod_reg[MAG_TOP-1:MAG_LSB];
        if (!side_reg[ALIGN_PROD].neg)
            gain_next = mag[VALUE_W-1] ? VAL_MAX : $signed(mag);
        else
            gain_next = mag[VALUE_W-1] ? VAL_MIN : -$signed(mag);
    end

    always_ff @(posedge clk)
    begin
        f_reg     <= F_W'(1 << FRAC_W) + F_W'(p10[P10_W-1:RECIP10_SH]);
        m_reg     <= M_W'(side_reg[ALIGN_F].ud) * M_W'(f_reg);
        pp_ll_reg <= PROD_W'(m_reg[ML_W-1:0]) * PROD_W'(side_reg[ALIGN_M].pred[PL_W-1:0]);
        pp_lh_reg <= PROD_W'(m_reg[ML_W-1:0]) * PROD_W'(side_reg[ALIGN_M].pred[PRED_W-1:PL_W]);
        pp_hl_reg <= PROD_W'(m_reg[M_W-1:ML_W]) * PROD_W'(side_reg[ALIGN_M].pred[PL_W-1:0]);
        pp_hh_reg <= PROD_W'(m_reg[M_W-1:ML_W]) * PROD_W'(side_reg[ALIGN_M].pred[PRED_W-1:PL_W]);
        prod_reg  <= pp_ll_reg + (pp_lh_reg << PL_W) + (pp_hl_reg << ML_W)
                   + (pp_hh_reg << (ML_W + PL_W));
        gain_dly_reg[0] <= gain_next;
        // hold the gain until the quotient catches up
        for (int k = 1; k <= GAIN_DLY; k++)
            gain_dly_reg[k] <= gain_dly_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Tail: move cost, net benefit, approval and result registers
    // ------------------------------------------------------------------
    logic                      a_pinned_reg, b_pinned_reg;
    logic [DIR_W-1:0]          a_dir_reg, b_dir_reg;
    logic signed [VALUE_W-1:0] a_gain_reg, b_gain_reg;
    logic [COST_W-1:0]         a_cost_reg, b_cost_reg;
    logic signed [VALUE_W-1:0] b_net_reg;
    logic signed [VALUE_W:0]   net_wide;

    logic [DIR_W-1:0]          direction_reg;
    logic                      approved_reg;
    logic signed [VALUE_W-1:0] gain_reg;
    logic [COST_W-1:0]         move_cost_reg;
    logic signed [VALUE_W-1:0] net_gain_reg;

    assign net_wide = {a_gain_reg[VALUE_W-1], a_gain_reg} - $signed({2'b00, a_cost_reg});

    always_ff @(posedge clk)
    begin
        a_pinned_reg <= side_reg[ALIGN_QUOT].pinned;
        a_dir_reg    <= side_reg[ALIGN_QUOT].dir;
        a_gain_reg   <= gain_dly_reg[GAIN_DLY];
        a_cost_reg   <= COST_W'(quot) + COST_W'({side_reg[ALIGN_QUOT].lsum, {FRAC_W{1'b0}}});

        b_pinned_reg <= a_pinned_reg;
        b_dir_reg    <= a_dir_reg;
        b_gain_reg   <= a_gain_reg;
        b_cost_reg   <= a_cost_reg;
        // clamp at the most negative value on underflow
        b_net_reg    <= (net_wide[VALUE_W] && !net_wide[VALUE_W-1]) ? VAL_MIN
                      : net_wide[VALUE_W-1:0];

        if (b_pinned_reg)
        begin
            direction_reg <= DIR_NONE;
            approved_reg  <= 1'b0;
            gain_reg      <= '0;
            move_cost_reg <= '0;
            net_gain_reg  <= '0;
        end
        else
        begin
            direction_reg <= b_dir_reg;
            approved_reg  <= b_net_reg > $signed({{(VALUE_W-THR_W){1'b0}}, threshold_reg});
            gain_reg      <= b_gain_reg;
            move_cost_reg <= b_cost_reg;
            net_gain_reg  <= b_net_reg;
        end
    end

    assign done      = vld_reg[PIPE_DEPTH-1];
    assign direction = direction_reg;
    assign approved  = approved_reg;
    assign gain      = gain_reg;
    assign move_cost = move_cost_reg;
    assign net_gain  = net_gain_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result strobe without a matching transfer");

    a_pinned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(pinned && start && !busy, PIPE_DEPTH)
        |-> direction == DIR_NONE && !approved && gain == 0 && move_cost == 0)
        else $error("pinned page produced a non-zero result");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PRE_STAGES-1+ALIGN_ROOT]
        |-> (34'(sq_root) * 34'(sq_root) <= 34'($past(sqsum_reg, SQ_STAGES)))
            && ((34'(sq_root) + 34'd1) * (34'(sq_root) + 34'd1)
                > 34'($past(sqsum_reg, SQ_STAGES))))
        else $error("square root out of bounds");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PRE_STAGES-1+ALIGN_QUOT]
        |-> (80'(quot) * 80'($past(s3_bw_reg, DIV_STAGES))
                <= 80'($past(s3_numer_reg, DIV_STAGES)))
            && ((80'(quot) + 80'd1) * 80'($past(s3_bw_reg, DIV_STAGES))
                > 80'($past(s3_numer_reg, DIV_STAGES))))
        else $error("move cost quotient out of bounds");

endmodule

// ----- tb/tb_tier_migration_evaluator.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Tier migration evaluator testbench
// Streams page requests through the evaluator under several tier tables and
// weight settings, predicts every result in place and checks each field of
// every result strobe in order. Sender gaps vary by phase.
// ============================================================================
module tb_tier_migration_evaluator;
    import tme_pkg::*;

    localparam int RESULT_LATENCY = 60;
    localparam int CYCLE_LIMIT    = 2000000;

    typedef struct packed {
        logic                  pinned;
        logic [CNT_W-1:0]      hit_count;
        logic [VEL_W-1:0]      vel_x;
        logic [VEL_W-1:0]      vel_y;
        logic [VEL_W-1:0]      vel_z;
        logic [SIZE_W-1:0]     page_size;
        logic [TIER_IDX_W-1:0] src_tier;
        logic [TIER_IDX_W-1:0] to_tier;
    } page_req_t;

    typedef struct packed {
        logic [DIR_W-1:0]   direction;
        logic               approved;
        logic [VALUE_W-1:0] gain;
        logic [COST_W-1:0]  move_cost;
        logic [VALUE_W-1:0] net_gain;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic pinned;
    logic [CNT_W-1:0] hit_count;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [SIZE_W-1:0] page_size;
    logic [TIER_IDX_W-1:0] src_tier;
    logic [TIER_IDX_W-1:0] to_tier;
    logic done;
    logic [DIR_W-1:0] direction;
    logic approved;
    logic signed [VALUE_W-1:0] gain;
    logic [COST_W-1:0] move_cost;
    logic signed [VALUE_W-1:0] net_gain;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tier_migration_evaluator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pinned       (pinned),
        .hit_count    (hit_count),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .page_size    (page_size),
        .src_tier     (src_tier),
        .to_tier      (to_tier),
        .done         (done),
        .direction    (direction),
        .approved     (approved),
        .gain         (gain),
        .move_cost    (move_cost),
        .net_gain     (net_gain),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the configuration registers
    logic [TIER_WORD_W-1:0] tier_tab [TME_NUM_TIERS];
    logic [WEIGHT_W-1:0]    en_wt;
    logic [WEIGHT_W-1:0]    lat_wt;
    logic [THR_W-1:0]       approve_thr;
    logic [HOR_W-1:0]       horizon_len;

    page_req_t pending_reqs[$];
    verdict_t  expected_verdicts[$];
    int        idle_pct;
    int        error_count;
    int        checked_count;
    int        approved_count;
    int        pinned_count;
    longint    cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    function automatic logic [63:0] speed_mag(input logic [VEL_W-1:0] v);
        return v[VEL_W-1] ? 64'h10000 - {48'd0, v} : {48'd0, v};
    endfunction

    function automatic logic [63:0] access_cost(input logic [TIER_WORD_W-1:0] w);
        return {48'd0, lat_wt} * {48'd0, w[15:0]} + {48'd0, en_wt} * {48'd0, w[31:16]};
    endfunction

    // Score one page request against the current shadow configuration
    function automatic verdict_t score_migration(input page_req_t r);
        verdict_t v;
        logic [1:0] ft, tt;
        logic [TIER_WORD_W-1:0] wf, wt;
        logic [63:0] cf, ct, ud, sq, n, f, base, pred, bwf, bwt, bw, cost;
        logic [127:0] prod, mag128;
        logic [63:0] mag;
        logic neg;
        logic signed [64:0] g, net65;
        logic signed [63:0] gs;
        v = '0;
        if (r.pinned)
            return v;
        ft = (r.src_tier >= TME_NUM_TIERS) ? 2'(TME_NUM_TIERS - 1) : r.src_tier;
        tt = (r.to_tier >= TME_NUM_TIERS) ? 2'(TME_NUM_TIERS - 1) : r.to_tier;
        wf = tier_tab[ft];
        wt = tier_tab[tt];
        cf = access_cost(wf);
        ct = access_cost(wt);
        neg = ct > cf;
        ud = neg ? ct - cf : cf - ct;
        sq = speed_mag(r.vel_x) * speed_mag(r.vel_x) + speed_mag(r.vel_y) * speed_mag(r.vel_y)
           + speed_mag(r.vel_z) * speed_mag(r.vel_z);
        n = {32'd0, int_sqrt(sq)};
        f = 64'd65536 + (n * 64'd256) / 64'd10;
        base = (r.hit_count == 0) ? 64'd1 : {32'd0, r.hit_count};
        pred = base * {48'd0, horizon_len};
        prod = {64'd0, ud * f} * {64'd0, pred};
        mag128 = prod >> 16;
        mag = (mag128[127:64] != 0) ? {64{1'b1}} : mag128[63:0];
        if (!neg)
            gs = mag[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mag);
        else if (mag > 64'h7FFF_FFFF_FFFF_FFFF)
            gs = 64'sh8000_0000_0000_0000;
        else
            gs = -$signed(mag);
        bwf = {33'd0, wf[62:32]};
        bwt = {33'd0, wt[62:32]};
        bw = (bwf < bwt) ? bwf : bwt;
        if (bw == 0)
            bw = 1;
        cost = ({32'd0, r.page_size} << 16) / bw;
        cost = cost + (({48'd0, wf[15:0]} + {48'd0, wt[15:0]} + {48'd0, wf[31:16]}
             + {48'd0, wt[31:16]}) << 16);
        g = gs;
        net65 = g - $signed({1'b0, cost});
        if (net65 < -(65'sd1 <<< 63))
            net65 = -(65'sd1 <<< 63);
        v.direction = (tt < ft) ? DIR_UP : (tt > ft) ? DIR_DOWN : DIR_NONE;
        v.approved = (net65 > $signed({33'd0, approve_thr}));
        v.gain = gs;
        v.move_cost = cost[COST_W-1:0];
        v.net_gain = net65[63:0];
        return v;
    endfunction

    // Driver: present the next request at the falling edge, hold while busy
    logic last_taken;
    always @(negedge clk)
    begin
        if (rst_n && start && !last_taken)
            start <= 1'b1;
        else if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            page_req_t r;
            r = pending_reqs.pop_front();
            start        <= 1'b1;
            pinned       <= r.pinned;
            hit_count    <= r.hit_count;
            vel_x        <= r.vel_x;
            vel_y        <= r.vel_y;
            vel_z        <= r.vel_z;
            page_size    <= r.page_size;
            src_tier     <= r.src_tier;
            to_tier      <= r.to_tier;
        end
        else
            start <= 1'b0;
    end

    // Monitor: predict on each request transfer, check each result strobe
    always @(posedge clk)
    begin
        last_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (start && !busy)
            begin
                page_req_t r;
                r = '{pinned, hit_count, vel_x, vel_y, vel_z, page_size, src_tier, to_tier};
                expected_verdicts.push_back(score_migration(r));
            end
            if (done)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    error_count++;
                end
                else
                begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    checked_count++;
                    if (e.approved)
                        approved_count++;
                    if (direction !== e.direction)
                    begin
                        $display("%0t: direction exp %0d got %0d", $time, e.direction, direction);
                        error_count++;
                    end
                    if (approved !== e.approved)
                    begin
                        $display("%0t: approved exp %0d got %0d", $time, e.approved, approved);
                        error_count++;
                    end
                    if (gain !== e.gain)
                    begin
                        $display("%0t: gain exp %0d got %0d", $time,
                                 $signed(e.gain), gain);
                        error_count++;
                    end
                    if (move_cost !== e.move_cost)
                    begin
                        $display("%0t: move_cost exp %0d got %0d", $time,
                                 e.move_cost, move_cost);
                        error_count++;
                    end
                    if (net_gain !== e.net_gain)
                    begin
                        $display("%0t: net_gain exp %0d got %0d", $time,
                                 $signed(e.net_gain), net_gain);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TIER0:      tier_tab[0] = val[TIER_WORD_W-1:0];
            REG_TIER1:      tier_tab[1] = val[TIER_WORD_W-1:0];
            REG_TIER2:      tier_tab[2] = val[TIER_WORD_W-1:0];
            REG_TIER3:      tier_tab[3] = val[TIER_WORD_W-1:0];
            REG_EN_WEIGHT:  en_wt = val[WEIGHT_W-1:0];
            REG_LAT_WEIGHT: lat_wt = val[WEIGHT_W-1:0];
            REG_THRESHOLD:  approve_thr = val[THR_W-1:0];
            REG_HORIZON:    horizon_len = val[HOR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued request went out and every result came back
    task automatic drain;
        while (pending_reqs.size() != 0 || start || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_vel();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic page_req_t random_req();
        page_req_t r;
        r.pinned    = ($urandom_range(9) == 0);
        r.hit_count = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
        r.vel_x     = pick_vel();
        r.vel_y     = pick_vel();
        r.vel_z     = pick_vel();
        r.page_size = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
        r.src_tier  = 2'($urandom_range(3));
        r.to_tier   = 2'($urandom_range(3));
        return r;
    endfunction

    function automatic logic [63:0] random_tier_word();
        case ($urandom_range(4))
            0: return 64'h7FFF_FFFF_FFFF_FFFF;
            1: return 64'd0;
            2: return {1'b0, 31'($urandom_range(3)), $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Apply one configuration setting: tier table plus weights and limits
    task automatic program_setting(input int kind);
        for (int t = 0; t < TME_NUM_TIERS; t++)
            write_reg(CFG_IDX_W'(t), random_tier_word());
        case (kind)
            0:
            begin
                write_reg(REG_EN_WEIGHT, 64'd0);
                write_reg(REG_LAT_WEIGHT, 64'hFFFF);
                write_reg(REG_THRESHOLD, 64'd0);
                write_reg(REG_HORIZON, 64'd0);
            end
            1:
            begin
                write_reg(REG_EN_WEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_LAT_WEIGHT, 64'd0);
                write_reg(REG_THRESHOLD, 64'hFFFF_FFFF);
                write_reg(REG_HORIZON, 64'hFFFF);
            end
            default:
            begin
                write_reg(REG_EN_WEIGHT, {$urandom, $urandom});
                write_reg(REG_LAT_WEIGHT, {$urandom, $urandom});
                write_reg(REG_THRESHOLD, 64'($urandom_range(1 << 20)));
                write_reg(REG_HORIZON, 64'($urandom_range(64)));
            end
        endcase
    endtask

    initial
    begin
        page_req_t r;
        int        phase_pct [4];
        phase_pct = '{0, 55, 0, 27};
        rst_n = 1'b0;
        start = 1'b0;
        pinned = 1'b0;
        hit_count = '0;
        vel_x = '0;
        vel_y = '0;
        vel_z = '0;
        page_size = '0;
        src_tier = '0;
        to_tier = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        error_count = 0;
        checked_count = 0;
        approved_count = 0;
        pinned_count = 0;
        cycle_count = 0;
        for (int t = 0; t < TME_NUM_TIERS; t++)
            tier_tab[t] = '0;
        en_wt = EN_WEIGHT_RST;
        lat_wt = LAT_WEIGHT_RST;
        approve_thr = THRESHOLD_RST;
        horizon_len = HORIZON_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: all tiers zero, so cost reduces to the size term
        r = '{1'b0, 32'd0, 16'd0, 16'd0, 16'd0, 32'd4096, 2'd0, 2'd3};
        pending_reqs.push_back(r);
        drain();

        // Directed: extremes of every field, every direction, pinned pages
        write_reg(REG_TIER0, {1'b0, 31'd1, 16'd0, 16'd1});
        write_reg(REG_TIER1, {1'b0, 31'd100, 16'd50, 16'd200});
        write_reg(REG_TIER2, {1'b0, 31'h7FFF_FFFF, 16'hFFFF, 16'h8000});
        write_reg(REG_TIER3, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_HORIZON, 64'hFFFF);
        pending_reqs.push_back('{1'b0, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                 32'hFFFF_FFFF, 2'd3, 2'd0});
        pending_reqs.push_back('{1'b0, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000,
                                 32'hFFFF_FFFF, 2'd0, 2'd3});
        pending_reqs.push_back('{1'b1, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'h0001,
                                 32'hFFFF_FFFF, 2'd0, 2'd3});
        pending_reqs.push_back('{1'b0, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 2'd1, 2'd1});
        pending_reqs.push_back('{1'b0, 32'd1, 16'hFFFF, 16'd1, 16'd0, 32'd1, 2'd2, 2'd1});
        pending_reqs.push_back('{1'b0, 32'd7, 16'h0100, 16'd0, 16'd0, 32'd65536, 2'd1, 2'd2});
        pending_reqs.push_back('{1'b0, 32'd3, 16'd0, 16'hFF00, 16'd0, 32'd123, 2'd3, 2'd3});
        pending_reqs.push_back('{1'b1, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 2'd1, 2'd1});
        pending_reqs.push_back('{1'b0, 32'h8000_0000, 16'h5555, 16'hAAAA, 16'h1234,
                                 32'h8000_0000, 2'd2, 2'd0});
        pending_reqs.push_back('{1'b0, 32'd1, 16'd0, 16'd0, 16'h7FFF, 32'd4096, 2'd0, 2'd1});
        drain();
        write_reg(REG_HORIZON, 64'd0);
        pending_reqs.push_back('{1'b0, 32'hFFFF_FFFF, 16'h7FFF, 16'd0, 16'd0,
                                 32'd4096, 2'd0, 2'd2});
        pending_reqs.push_back('{1'b0, 32'd5, 16'd0, 16'd0, 16'd0, 32'd4096, 2'd3, 2'd1});
        drain();

        // Random phases: new setting per phase, sender gaps vary
        for (int p = 0; p < 8; p++)
        begin
            program_setting(p);
            idle_pct = phase_pct[p % 4];
            for (int i = 0; i < 92; i++)
            begin
                r = random_req();
                if (r.pinned)
                    pinned_count++;
                pending_reqs.push_back(r);
            end
            drain();
        end

        $display("Checked %0d results (%0d approved), %0d random pinned pages,",
                 checked_count, approved_count, pinned_count);
        $display("over reset, extreme and random tier tables and sender gap levels.");
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tme_pkg.sv
hw/rtl/tme_sqrt_pipe.sv
hw/rtl/tme_div_pipe.sv
hw/rtl/tier_migration_evaluator.sv
tb/tb_tier_migration_evaluator.sv
